@@ rtl/dcfr_pkg.sv @@
package dcfr_pkg;

	localparam int unsigned BUFFER_DEPTH_DEF = 256;

	// Item modes.
	localparam logic [1:0] MODE_RX      = 2'd0;
	localparam logic [1:0] MODE_READ    = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_ACCEPT_WHILE_CONNECTING = 1'b0;
	localparam logic CFG_PREEMPT_SCAN            = 1'b1;

	// Framing characters.
	localparam logic [7:0] CH_SYNC = 8'h24;
	localparam logic [7:0] CH_CR   = 8'h0d;
	localparam logic [7:0] CH_LF   = 8'h0a;

	// Link activity codes that the gate looks at.
	localparam logic [3:0] ACT_IDLE    = 4'd0;
	localparam logic [3:0] ACT_CONNECT = 4'd1;
	localparam logic [3:0] ACT_SCAN    = 4'd4;

	// Status reported for one item, taken after the item has been applied.
	typedef struct packed {
		logic       done;
		logic       cr;
		logic       sync;
		logic [7:0] count;
		logic       act_rst;
		logic       ovf;
	} dcfr_status_t;

endpackage

@@ rtl/dcfr_ram.sv @@
module dcfr_ram import dcfr_pkg::*; #(
	parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/dcfr_ctrl.sv @@
module dcfr_ctrl import dcfr_pkg::*; #(
	parameter int unsigned DEPTH = BUFFER_DEPTH_DEF,
	parameter int unsigned CW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [1:0]    mode,
	input  logic [7:0]    rx_byte,
	input  logic [3:0]    link_activity,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic          cfg_data,
	output dcfr_status_t  status_nxt,
	output logic          mem_we,
	output logic [CW-1:0] mem_waddr,
	output logic [7:0]    mem_wdata
);

	localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);

	logic          awc_q;
	logic          preempt_q;
	logic          sync_q;
	logic          cr_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic          sync_d;
	logic          cr_d;
	logic          done_d;
	logic [CW-1:0] cnt_d;
	logic          act_rst;
	logic          ovf;
	logic          wr;
	logic          preempt_hit;
	logic          gate_open;
	logic [CW+7:0] cnt_ext;

	always_comb begin
		sync_d      = sync_q;
		cr_d        = cr_q;
		done_d      = done_q;
		cnt_d       = cnt_q;
		act_rst     = 1'b0;
		ovf         = 1'b0;
		wr          = 1'b0;
		preempt_hit = 1'b0;
		gate_open   = 1'b0;
		case (mode)
			MODE_RX: begin
				if (!done_q) begin
					if (rx_byte == CH_SYNC) begin
						sync_d = 1'b1;
						cnt_d  = '0;
						cr_d   = 1'b0;
					end
					if (sync_d) begin
						preempt_hit = preempt_q && (link_activity == ACT_SCAN);
						if (preempt_hit) begin
							act_rst = 1'b1;
							cnt_d   = '0;
							cr_d    = 1'b0;
						end
						gate_open = preempt_hit || (link_activity == ACT_IDLE) ||
							(awc_q && (link_activity == ACT_CONNECT));
						if (gate_open) begin
							if (cr_d) begin
								if (rx_byte != CH_LF) begin
									cnt_d = '0;
									cr_d  = 1'b0;
								end else begin
									done_d = 1'b1;
									sync_d = 1'b0;
								end
							end else if (rx_byte == CH_CR) begin
								cr_d = 1'b1;
							end else begin
								wr = 1'b1;
								if (cnt_d == LAST) begin
									ovf   = 1'b1;
									cnt_d = '0;
								end else begin
									cnt_d = cnt_d + 1'b1;
								end
							end
						end
					end
				end
			end
			MODE_RELEASE: begin
				done_d = 1'b0;
				cr_d   = 1'b0;
				sync_d = 1'b0;
				cnt_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// The write address is the count before the increment; every path that
	// stores a byte leaves the earlier clears already folded into it, so take
	// it from the same point of the update.
	logic [CW-1:0] waddr;
	always_comb begin
		waddr = cnt_q;
		if ((rx_byte == CH_SYNC) || preempt_hit || cr_q) begin
			waddr = '0;
		end
	end

	assign cnt_ext   = {8'd0, cnt_d};
	assign mem_we    = take && wr;
	assign mem_waddr = waddr;
	assign mem_wdata = rx_byte;

	assign status_nxt.done    = done_d;
	assign status_nxt.cr      = cr_d;
	assign status_nxt.sync    = sync_d;
	assign status_nxt.count   = cnt_ext[7:0];
	assign status_nxt.act_rst = act_rst;
	assign status_nxt.ovf     = ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awc_q     <= 1'b0;
			preempt_q <= 1'b1;
			sync_q    <= 1'b0;
			cr_q      <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ACCEPT_WHILE_CONNECTING: awc_q <= cfg_data;
					CFG_PREEMPT_SCAN:            preempt_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (take) begin
				sync_q <= sync_d;
				cr_q   <= cr_d;
				done_q <= done_d;
				cnt_q  <= cnt_d;
			end
		end
	end

endmodule

@@ rtl/dollar_crlf_frame_receiver_top.sv @@
// Line receiver that frames serial bytes between a '$' and a CR LF pair and
// keeps the line in an on-chip buffer of BUFFER_DEPTH bytes. Every accepted
// input beat gives exactly one result beat: mode 0 feeds a received byte,
// mode 1 reads back a stored byte at read_index (0 outside the buffer), mode 2
// releases a finished frame and clears the status, and mode 3 just reports
// the status. The block takes one beat per clock cycle for as long as the
// result side keeps up; a result passes stage one and the output register.
// The frame flags and the fill count are updated in the cycle of acceptance,
// while the line buffer is a single memory with one write port, used by the
// received byte in that same cycle, and one registered read port, whose data
// is ready in the following stage. A result that is not taken waits in an
// output register while the next beat is already being worked on. The two
// configuration registers are written through cfg_we, cfg_index and
// cfg_data; write them only while no beat is in flight.
module dollar_crlf_frame_receiver_top import dcfr_pkg::*; #(
	parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic [7:0] rx_byte,
	input  logic [3:0] link_activity,
	input  logic [7:0] read_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       frame_done,
	output logic       cr_seen,
	output logic [7:0] byte_count,
	output logic       in_sync,
	output logic [7:0] read_data,
	output logic       activity_reset,
	output logic       overflowed,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic       cfg_data
);

	localparam int unsigned AW = $clog2(BUFFER_DEPTH);

	logic          take;
	logic          s1_adv;
	dcfr_status_t  status_nxt;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [AW+7:0] ridx_ext;
	logic          ridx_ok;

	logic          valid_s1;
	dcfr_status_t  status_s1;
	logic          rd_sel_s1;

	logic          out_valid_q;
	dcfr_status_t  status_q;
	logic [7:0]    rdata_q;

	// Stage one moves on whenever the output register is empty or drained.
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	dcfr_ctrl #(
		.DEPTH (BUFFER_DEPTH),
		.CW    (AW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.mode          (mode),
		.rx_byte       (rx_byte),
		.link_activity (link_activity),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.status_nxt    (status_nxt),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata)
	);

	// Read index may be narrower or wider than the buffer address; positions
	// at or past the end of the buffer read as zero.
	assign ridx_ext  = {{AW{1'b0}}, read_index};
	assign mem_raddr = ridx_ext[AW-1:0];
	assign ridx_ok   = (32'(read_index) < 32'(BUFFER_DEPTH));
	assign mem_re    = take && (mode == MODE_READ) && ridx_ok;

	// The read data register only loads on a read, so it holds while stage
	// one is stalled.
	dcfr_ram #(
		.DEPTH (BUFFER_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_s1 <= status_nxt;
			rd_sel_s1 <= mem_re;
		end
		if (s1_adv) begin
			status_q <= status_s1;
			rdata_q  <= rd_sel_s1 ? mem_rdata : 8'd0;
		end
	end

	assign out_valid      = out_valid_q;
	assign frame_done     = status_q.done;
	assign cr_seen        = status_q.cr;
	assign byte_count     = status_q.count;
	assign in_sync        = status_q.sync;
	assign read_data      = rdata_q;
	assign activity_reset = status_q.act_rst;
	assign overflowed     = status_q.ovf;

	// A completed frame drops sync.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_done && in_sync))
		else $error("frame done while still in sync");

	// The CR flag is only ever set while synced, and stays on into done.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cr_seen) |-> (in_sync || frame_done))
		else $error("CR flag without sync");

	// An overflow wraps the count to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflowed) |-> (byte_count == 8'd0))
		else $error("overflow without count wrap");

	// A preempted scan clears the CR flag, so that byte cannot end a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && activity_reset) |-> !frame_done)
		else $error("frame completed on a preempting byte");

endmodule

@@ verif/dollar_crlf_frame_receiver_top_tb.sv @@
module dollar_crlf_frame_receiver_top_tb;
	import dcfr_pkg::*;

	// Mode 3 has no name in the package; it only reports the status.
	localparam logic [1:0] MODE_STATUS = 2'd3;

	// One input beat as the sender offers it.
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic [3:0] act;
		logic [7:0] idx;
	} rx_beat_t;

	// Framing state that the predictor carries from beat to beat.
	typedef struct packed {
		logic       done;
		logic       cr;
		logic       synced;
		logic [7:0] count;
	} framer_state_t;

	// One result beat, field for field as the block reports it.
	typedef struct packed {
		logic       done;
		logic       cr;
		logic [7:0] count;
		logic       sync;
		logic [7:0] rd;
		logic       act_rst;
		logic       ovf;
	} line_status_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] mode = 2'd0;
	logic [7:0] rx_byte = 8'd0;
	logic [3:0] link_activity = 4'd0;
	logic [7:0] read_index = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       frame_done;
	logic       cr_seen;
	logic [7:0] byte_count;
	logic       in_sync;
	logic [7:0] read_data;
	logic       activity_reset;
	logic       overflowed;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic       cfg_data = 1'b0;

	dollar_crlf_frame_receiver_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.rx_byte(rx_byte),
		.link_activity(link_activity),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_done(frame_done),
		.cr_seen(cr_seen),
		.byte_count(byte_count),
		.in_sync(in_sync),
		.read_data(read_data),
		.activity_reset(activity_reset),
		.overflowed(overflowed),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Beats waiting to be offered, and results that accepted beats still owe.
	rx_beat_t     beats_to_send [$];
	line_status_t awaited_status [$];

	// Configuration as the testbench last wrote it; reset values to start.
	logic cfg_acc = 1'b0;
	logic cfg_pre = 1'b1;

	// Checking side: framing state and line buffer as of the last accepted beat.
	framer_state_t line_st = '0;
	logic [7:0]    line_mem [256];

	// Planning side: the same framing state, run ahead while beats are queued,
	// so that reads only ever target buffer entries that have been written.
	// Writes always land at the fill count, so the written entries form a
	// prefix of the buffer and plan_hi is its length.
	framer_state_t plan_st = '0;
	int            plan_hi = 0;
	int            plan_count = 0;

	int mismatch_count = 0;

	// Idling controls: calm for both sides, the hold ones for the receiver.
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	rx_beat_t      obs_beat;
	rx_beat_t      next_beat;
	framer_state_t obs_next;
	line_status_t  want;
	logic          obs_we;
	logic [7:0]    obs_waddr;
	logic          obs_ar;
	logic          obs_ovf;

	initial begin
		forever #5 clk = ~clk;
	end

	// Works out the framing state after one beat. The buffer write, if any,
	// is handed back to the caller, which owns its copy of the buffer.
	function automatic void advance_framer(input framer_state_t s, input rx_beat_t bt,
			input logic acc, input logic pre, output framer_state_t n,
			output logic we, output logic [7:0] waddr, output logic act_rst,
			output logic ovf);
		logic [3:0] act;
		n = s;
		we = 1'b0;
		waddr = 8'd0;
		act_rst = 1'b0;
		ovf = 1'b0;
		act = bt.act;
		case (bt.mode)
			MODE_RX: begin
				// A finished frame swallows every byte, a dollar sign included.
				if (!n.done) begin
					if (bt.rx_byte == CH_SYNC) begin
						n.synced = 1'b1;
						n.count = 8'd0;
						n.cr = 1'b0;
					end
					if (n.synced) begin
						// A scan reply gets preempted: the link goes back to idle and
						// the frame restarts, then the byte is taken as if idle.
						if (pre && act == ACT_SCAN) begin
							act_rst = 1'b1;
							act = ACT_IDLE;
							n.count = 8'd0;
							n.cr = 1'b0;
						end
						if (act == ACT_IDLE || (acc && act == ACT_CONNECT)) begin
							if (n.cr) begin
								if (bt.rx_byte != CH_LF) begin
									n.count = 8'd0;
									n.cr = 1'b0;
								end else begin
									n.done = 1'b1;
									n.synced = 1'b0;
								end
							end else if (bt.rx_byte == CH_CR) begin
								n.cr = 1'b1;
							end else begin
								we = 1'b1;
								waddr = n.count;
								// The count is as wide as the buffer index, so a full
								// buffer wraps it to zero by itself.
								n.count = n.count + 8'd1;
								ovf = (n.count == 8'd0);
							end
						end
					end
				end
			end
			MODE_RELEASE: begin
				n = '0;
			end
			default: begin
			end
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned exp_val);
		if (got != exp_val)
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_val));
	endtask

	// Queues one beat and runs it through the planning copy of the framer.
	// A read of an entry not yet written is turned into a legal one.
	task automatic queue_beat(input logic [1:0] m, input logic [7:0] b,
			input logic [3:0] a, input logic [7:0] ix);
		rx_beat_t      bt;
		framer_state_t nxt;
		logic          we;
		logic [7:0]    wa;
		logic          ar;
		logic          ov;
		bt = '{m, b, a, ix};
		if (bt.mode == MODE_READ && int'(bt.idx) >= plan_hi) begin
			if (plan_hi == 0)
				bt.mode = MODE_STATUS;
			else
				bt.idx = 8'($urandom_range(plan_hi - 1));
		end
		advance_framer(plan_st, bt, cfg_acc, cfg_pre, nxt, we, wa, ar, ov);
		if (we && int'(wa) >= plan_hi)
			plan_hi = int'(wa) + 1;
		// Every queued beat counts toward the amount asked for.
		plan_count++;
		plan_st = nxt;
		beats_to_send.push_back(bt);
	endtask

	// Any byte, with the framing characters drawn often.
	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return CH_SYNC;
		else if (r < 20)
			return CH_CR;
		else if (r < 30)
			return CH_LF;
		return 8'($urandom);
	endfunction

	// A payload byte: neither a dollar sign nor a carriage return.
	function automatic logic [7:0] payload_byte();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == CH_SYNC || b == CH_CR)
			b = 8'($urandom);
		return b;
	endfunction

	// Link activity, mostly idle, with the connect and scan codes well drawn.
	function automatic logic [3:0] pick_act();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return ACT_IDLE;
		else if (r < 80)
			return ACT_CONNECT;
		else if (r < 90)
			return ACT_SCAN;
		return 4'($urandom_range(9));
	endfunction

	// A frame with random content: the dollar sign, a payload of len bytes
	// with the odd broken CR, the CR LF pair (always when tidy, else mostly),
	// a few bytes after completion, some read-backs and usually a release. An
	// untidy frame mixes in stray framing bytes and busy link states.
	task automatic queue_frame(input int len, input bit tidy);
		int i;
		queue_beat(MODE_RX, CH_SYNC, tidy ? ACT_IDLE : pick_act(), 8'($urandom));
		for (i = 0; i < len; i++) begin
			if (!tidy && $urandom_range(99) < 10) begin
				queue_beat(MODE_RX, rand_byte(), pick_act(), 8'($urandom));
			end else if ($urandom_range(99) < 5) begin
				queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'($urandom));
				queue_beat(MODE_RX, payload_byte(), ACT_IDLE, 8'($urandom));
			end else begin
				queue_beat(MODE_RX, payload_byte(),
					(tidy && $urandom_range(99) < 85) ? ACT_IDLE : pick_act(),
					8'($urandom));
			end
		end
		if (tidy || $urandom_range(99) < 70) begin
			queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'($urandom));
			queue_beat(MODE_RX, CH_LF, tidy ? ACT_IDLE : pick_act(), 8'($urandom));
		end
		repeat ($urandom_range(2))
			queue_beat(MODE_RX, rand_byte(), pick_act(), 8'($urandom));
		repeat ($urandom_range(2))
			queue_beat(MODE_READ, 8'($urandom), 4'($urandom_range(9)), 8'($urandom));
		if ($urandom_range(99) < 20)
			queue_beat(MODE_STATUS, 8'($urandom), 4'($urandom_range(9)), 8'($urandom));
		if ($urandom_range(99) < 85)
			queue_beat(MODE_RELEASE, 8'($urandom), 4'($urandom_range(9)), 8'($urandom));
	endtask

	// Mostly whole frames of random length, the rest single random beats.
	task automatic queue_random(input int amount);
		int start;
		start = plan_count;
		while (plan_count - start < amount) begin
			if ($urandom_range(99) < 70)
				queue_frame($urandom_range(1, 12), $urandom_range(99) < 70);
			else
				queue_beat(2'($urandom), rand_byte(), 4'($urandom_range(9)), 8'($urandom));
		end
	endtask

	// Returns once every queued beat has been sent and every result has come.
	// The check is made at the falling edge, clear of the clocked processes.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (beats_to_send.size() != 0 || in_valid || awaited_status.size() != 0);
	endtask

	task automatic write_cfg(input logic idx, input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ACCEPT_WHILE_CONNECTING)
			cfg_acc = val;
		else
			cfg_pre = val;
	endtask

	task automatic set_config(input logic acc, input logic pre);
		wait_drained();
		write_cfg(CFG_ACCEPT_WHILE_CONNECTING, acc);
		write_cfg(CFG_PREEMPT_SCAN, pre);
	endtask

	// Sender: offers the next queued beat whenever the channel is free, and
	// idles at random unless the calm stretch is on. A beat that is offered
	// stays put until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (beats_to_send.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
				next_beat = beats_to_send.pop_front();
				in_valid <= 1'b1;
				mode <= next_beat.mode;
				rx_byte <= next_beat.rx_byte;
				link_activity <= next_beat.act;
				read_index <= next_beat.idx;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls at random, except in the calm stretch. Once asked, it
	// holds off for a long run of cycles so that the block fills up and has
	// to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = 80;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 28);
		end
	end

	// Monitor: every accepted input beat is predicted here, before any result
	// of the same edge is checked, so the expectation is always in place.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				obs_beat = '{mode, rx_byte, link_activity, read_index};
				advance_framer(line_st, obs_beat, cfg_acc, cfg_pre, obs_next, obs_we,
					obs_waddr, obs_ar, obs_ovf);
				if (obs_we)
					line_mem[obs_waddr] = obs_beat.rx_byte;
				want.done = obs_next.done;
				want.cr = obs_next.cr;
				want.count = obs_next.count;
				want.sync = obs_next.synced;
				want.rd = (obs_beat.mode == MODE_READ) ? line_mem[obs_beat.idx] : 8'd0;
				want.act_rst = obs_ar;
				want.ovf = obs_ovf;
				line_st = obs_next;
				awaited_status.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (awaited_status.size() == 0) begin
					flag_mismatch("result beat with nothing expected");
				end else begin
					want = awaited_status.pop_front();
					check_field("frame_done", frame_done, want.done);
					check_field("cr_seen", cr_seen, want.cr);
					check_field("byte_count", byte_count, want.count);
					check_field("in_sync", in_sync, want.sync);
					check_field("read_data", read_data, want.rd);
					check_field("activity_reset", activity_reset, want.act_rst);
					check_field("overflowed", overflowed, want.ovf);
				end
			end
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset configuration: no connect frames, scan
		// replies preempted.
		queue_beat(MODE_STATUS, 8'hff, 4'd9, 8'hff);
		queue_beat(MODE_RELEASE, 8'h00, 4'd0, 8'h00);
		// Bytes before any dollar sign change nothing.
		queue_beat(MODE_RX, 8'h41, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'hff, 4'd9, 8'h80);
		// The dollar sign is stored as the first byte of the line.
		queue_beat(MODE_RX, CH_SYNC, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'h00, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'hff, ACT_IDLE, 8'h00);
		// Gate closed: a busy link and a connect frame with connects not taken.
		queue_beat(MODE_RX, 8'h55, 4'd2, 8'h00);
		queue_beat(MODE_RX, 8'h55, ACT_CONNECT, 8'h00);
		// A dollar sign with the gate closed still restarts the frame.
		queue_beat(MODE_RX, CH_SYNC, 4'd9, 8'h00);
		// A byte during a scan reply resets the activity and is then stored.
		queue_beat(MODE_RX, 8'h7e, ACT_SCAN, 8'h00);
		// A CR followed by anything but LF restarts the count.
		queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'h61, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'h41, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, CH_LF, ACT_IDLE, 8'h00);
		// Once the frame is done every byte is ignored, a dollar sign too.
		queue_beat(MODE_RX, CH_SYNC, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, 8'h42, ACT_IDLE, 8'h00);
		queue_beat(MODE_READ, 8'h00, ACT_IDLE, 8'h00);
		queue_beat(MODE_READ, 8'h00, ACT_IDLE, 8'h02);
		// Release clears the status but keeps the buffer.
		queue_beat(MODE_RELEASE, 8'h00, ACT_IDLE, 8'h00);
		queue_beat(MODE_READ, 8'h00, ACT_IDLE, 8'h01);
		queue_beat(MODE_RX, CH_LF, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'h00);
		queue_beat(MODE_STATUS, 8'h00, ACT_IDLE, 8'h00);
		queue_random(115);

		// Connect frames taken, scan replies not preempted. One long line
		// fills the whole buffer, wraps the count and is then read at both ends.
		set_config(1'b1, 1'b0);
		queue_beat(MODE_RX, CH_SYNC, ACT_IDLE, 8'h00);
		repeat (270)
			queue_beat(MODE_RX, payload_byte(), ACT_IDLE, 8'($urandom));
		queue_beat(MODE_RX, CH_CR, ACT_IDLE, 8'h00);
		queue_beat(MODE_RX, CH_LF, ACT_IDLE, 8'h00);
		queue_beat(MODE_READ, 8'h00, ACT_IDLE, 8'hff);
		queue_beat(MODE_READ, 8'h00, ACT_IDLE, 8'h00);
		queue_beat(MODE_RELEASE, 8'h00, ACT_IDLE, 8'h00);
		queue_random(115);

		// Both gate options on. The receiver holds off for a long while, and
		// halfway through the sender pauses until every result is back.
		set_config(1'b1, 1'b1);
		hold_req = 1'b1;
		queue_random(60);
		wait_drained();
		queue_random(60);

		// Both gate options off, with no idling on either side.
		set_config(1'b0, 1'b0);
		calm = 1'b1;
		queue_random(115);
		wait_drained();
		calm = 1'b0;

		// Back to the reset configuration.
		set_config(1'b0, 1'b1);
		queue_random(115);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Stop a run that hangs, well past the slowest legal run.
	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/dcfr_pkg.sv
rtl/dcfr_ram.sv
rtl/dcfr_ctrl.sv
rtl/dollar_crlf_frame_receiver_top.sv
verif/dollar_crlf_frame_receiver_top_tb.sv
